// ----- rtl/rclsc_pkg.sv -----
`timescale 1ns / 1ps
package rclsc_pkg;

    // Sample window and gap, in sample index units
    localparam int unsigned WINDOW_START = 70;
    localparam int unsigned WINDOW_END   = 230;
    localparam int unsigned GAP_START    = 182;
    localparam int unsigned GAP_END      = 193;

    typedef struct packed {
        logic [14:0] sample;
        logic [7:0]  sample_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] capacitance;
        logic               divide_by_zero;
    } t_out_item;

    typedef struct packed {
        logic        high_voltage_mode;
        logic [15:0] zero_offset;
        logic [15:0] scale_factor;
    } t_cfg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_HV_MODE = 2'd0;
    localparam logic [1:0] REG_ZERO    = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;

    // Operand selects of the shared multiplier
    localparam logic [3:0] MUL_YY  = 4'd0;  // y * y
    localparam logic [3:0] MUL_YA  = 4'd1;  // y * (y + y/16 + y/256)
    localparam logic [3:0] MUL_YH  = 4'd2;  // y * (hi - hi/4)
    localparam logic [3:0] MUL_HY8 = 4'd3;  // (hi/8) * (y/256)
    localparam logic [3:0] MUL_YT  = 4'd4;  // y * (t - t/8)
    localparam logic [3:0] MUL_IZ  = 4'd5;  // index * z
    localparam logic [3:0] MUL_SXM = 4'd6;  // sum x * mean of z
    localparam logic [3:0] MUL_SCL = 4'd7;  // adjusted sum xx * scale
    localparam logic [3:0] MUL_RCP = 4'd8;  // sum of z * reciprocal of count, upper half
    localparam logic [3:0] MUL_QN  = 4'd9;  // trial mean * count

    // Controller to datapath commands
    typedef struct packed {
        logic       in_load;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       acc_init;
        logic       acc_add;
        logic       hi_load;
        logic       sy_add;
        logic       sxy_add;
        logic       mean_load;
        logic       mean_fix;
        logic       div_start;
        logic       sxy_load;
        logic       out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic used;
        logic idx_end;
        logic div_done;
        logic sxy_zero;
    } t_sts;

    function automatic logic idx_used(input logic [7:0] i);
        logic in_win;
        logic in_gap;
        in_win = (int'(i) >= WINDOW_START) && (int'(i) <= WINDOW_END);
        in_gap = (int'(i) >= GAP_START) && (int'(i) < GAP_END);
        return in_win && !in_gap;
    endfunction

    function automatic logic [31:0] win_n();
        logic [31:0] s;
        s = '0;
        for (int k = 0; k < 256; k++) begin
            if (idx_used(8'(k))) s = s + 32'd1;
        end
        return s;
    endfunction

    function automatic logic [31:0] win_sx();
        logic [31:0] s;
        s = '0;
        for (int k = 0; k < 256; k++) begin
            if (idx_used(8'(k))) s = s + 32'(k);
        end
        return s;
    endfunction

    function automatic logic [31:0] win_sxx();
        logic [31:0] s;
        s = '0;
        for (int k = 0; k < 256; k++) begin
            if (idx_used(8'(k))) s = s + 32'(k * k);
        end
        return s;
    endfunction

    // Fixed sums over the used indexes
    localparam logic [31:0] N_C     = win_n();
    localparam logic [31:0] SX_C    = win_sx();
    localparam logic [31:0] SXX_RAW = win_sxx();
    localparam logic [31:0] SX_SQ   = SX_C * SX_C;
    localparam logic [31:0] SXX_ADJ = (N_C != 32'd0) ? (SXX_RAW - SX_SQ / N_C) : SXX_RAW;
    localparam logic [31:0] SXX_C   = SXX_ADJ >> 3;

    // floor(2^32 / count), clipped to 32 bits; the trial mean is low by at most one
    localparam logic [31:0] N_RECIP = (N_C <= 32'd1) ? 32'hFFFF_FFFF
                                      : 32'(64'h1_0000_0000 / {32'b0, N_C});

endpackage

// ----- rtl/rclsc_div.sv -----
`timescale 1ns / 1ps
module rclsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    // One restoring step per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    // Control: busy for 32 steps, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- rtl/rclsc_dp.sv -----
`timescale 1ns / 1ps
module rclsc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rclsc_pkg::t_cfg      i_cfg,
    input  rclsc_pkg::t_in_item  i_in,
    input  rclsc_pkg::t_cmd      i_cmd,
    output rclsc_pkg::t_sts      o_sts,
    output rclsc_pkg::t_out_item o_out
);
    import rclsc_pkg::*;

    logic [15:0] r_y;
    logic [7:0]  r_idx;
    logic [31:0] r_acc;
    logic [13:0] r_hi;
    logic [31:0] r_prod;
    logic [31:0] r_sy;
    logic [31:0] r_sxy_sum;
    logic [31:0] r_sxy;
    logic [31:0] r_mean;
    t_out_item   r_out;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_full;
    logic [15:0] y_sum;
    logic [13:0] hi_diff;
    logic [15:0] t_val;
    logic [15:0] t_diff;
    logic [31:0] mean;
    logic [31:0] rem_n;
    logic        div_done;
    logic [31:0] div_quo;

    always_comb begin
        y_sum   = r_y + (r_y >> 4) + (r_y >> 8);
        hi_diff = r_hi - (r_hi >> 2);
        t_val   = r_prod[15:0];
        t_diff  = t_val - (t_val >> 3);
        mean    = (N_C == 32'd0) ? 32'd0 : r_mean;
        rem_n   = r_sy - r_prod;
    end

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_YY: begin
                mul_a = {16'b0, r_y};
                mul_b = {16'b0, r_y};
            end
            MUL_YA: begin
                mul_a = {16'b0, r_y};
                mul_b = {16'b0, y_sum};
            end
            MUL_YH: begin
                mul_a = {16'b0, r_y};
                mul_b = {18'b0, hi_diff};
            end
            MUL_HY8: begin
                mul_a = {21'b0, r_hi[13:3]};
                mul_b = {24'b0, r_y[15:8]};
            end
            MUL_YT: begin
                mul_a = {16'b0, r_y};
                mul_b = {16'b0, t_diff};
            end
            MUL_IZ: begin
                mul_a = {24'b0, r_idx};
                mul_b = {16'b0, r_acc[31:16]};
            end
            MUL_SXM: begin
                mul_a = SX_C;
                mul_b = mean;
            end
            MUL_SCL: begin
                mul_a = SXX_C;
                mul_b = {16'b0, i_cfg.scale_factor};
            end
            MUL_RCP: begin
                mul_a = r_sy;
                mul_b = N_RECIP;
            end
            MUL_QN: begin
                mul_a = r_prod;
                mul_b = N_C;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = {32'b0, mul_a} * {32'b0, mul_b};

    // Latch the item, step the log approximation, and register the mean, the scaled xy sum and the output
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_y   <= i_cfg.high_voltage_mode ? (16'h8000 - {1'b0, i_in.sample})
                                             : {1'b0, i_in.sample};
            r_idx <= i_in.sample_index;
        end
        if (i_cmd.mul_en) begin
            r_prod <= (i_cmd.mul_sel == MUL_RCP) ? mul_full[63:32] : mul_full[31:0];
        end
        if (i_cmd.acc_init) begin
            r_acc <= {r_y, 16'b0};
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.hi_load) r_hi <= r_prod[31:18];
        // Take the trial mean, then bump it where the remainder reaches the count
        if (i_cmd.mean_load) begin
            r_mean <= r_prod;
        end else if (i_cmd.mean_fix && (rem_n >= N_C)) begin
            r_mean <= r_mean + 32'd1;
        end
        if (i_cmd.sxy_load) r_sxy <= (r_sxy_sum - r_prod) >> 6;
        if (i_cmd.out_load) begin
            r_out.divide_by_zero <= (r_sxy == 32'd0);
            r_out.capacitance    <= (r_sxy == 32'd0) ? '1
                                    : $signed(div_quo - {16'b0, i_cfg.zero_offset});
        end
    end

    // Running sums; index zero clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sy      <= '0;
            r_sxy_sum <= '0;
        end else begin
            if (i_cmd.in_load && i_in.sample_index == 8'd0) begin
                r_sy      <= '0;
                r_sxy_sum <= '0;
            end
            if (i_cmd.sy_add) r_sy <= r_sy + {16'b0, r_acc[31:16]};
            if (i_cmd.sxy_add) r_sxy_sum <= r_sxy_sum + r_prod;
        end
    end

    // Divider for the final quotient
    rclsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_sxy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        o_sts.used     = idx_used(r_idx);
        o_sts.idx_end  = (r_idx == 8'(WINDOW_END));
        o_sts.div_done = div_done;
        o_sts.sxy_zero = (r_sxy == 32'd0);
    end

    assign o_out = r_out;
endmodule

// ----- rtl/rclsc_ctrl.sv -----
`timescale 1ns / 1ps
module rclsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rclsc_pkg::t_sts i_sts,
    output rclsc_pkg::t_cmd o_cmd
);
    import rclsc_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_L1   = 5'd2;
    localparam logic [4:0] S_L2   = 5'd3;
    localparam logic [4:0] S_L3   = 5'd4;
    localparam logic [4:0] S_L4   = 5'd5;
    localparam logic [4:0] S_L5   = 5'd6;
    localparam logic [4:0] S_L6   = 5'd7;
    localparam logic [4:0] S_L7   = 5'd8;
    localparam logic [4:0] S_F0   = 5'd9;
    localparam logic [4:0] S_F1   = 5'd10;
    localparam logic [4:0] S_F2   = 5'd11;
    localparam logic [4:0] S_F3   = 5'd12;
    localparam logic [4:0] S_F4   = 5'd13;
    localparam logic [4:0] S_F5   = 5'd14;
    localparam logic [4:0] S_F6   = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // Sequence the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_load = i_in_valid;
                if (i_in_valid) n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.used) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_sel  = MUL_YY;
                    o_cmd.acc_init = 1'b1;
                    n_state = S_L1;
                end else if (i_sts.idx_end) begin
                    n_state = S_F0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_L1: begin
                o_cmd.hi_load = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YA;
                n_state = S_L2;
            end
            S_L2: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YH;
                n_state = S_L3;
            end
            S_L3: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HY8;
                n_state = S_L4;
            end
            S_L4: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YT;
                n_state = S_L5;
            end
            S_L5: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_L6;
            end
            S_L6: begin
                o_cmd.sy_add  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_IZ;
                n_state = S_L7;
            end
            S_L7: begin
                o_cmd.sxy_add = 1'b1;
                n_state = i_sts.idx_end ? S_F0 : S_IDLE;
            end
            S_F0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RCP;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.mean_load = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_QN;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.mean_fix = 1'b1;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SXM;
                n_state = S_F4;
            end
            S_F4: begin
                o_cmd.sxy_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_SCL;
                n_state = S_F5;
            end
            S_F5: begin
                if (i_sts.sxy_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_F6;
                end
            end
            S_F6: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/rc_log_slope_capacitance.sv -----
`timescale 1ns / 1ps
// Capacitance from the log-linearized RC charge curve.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one
// accumulated sample with its index per transfer. Index zero clears the
// running sums; indexes inside the window and outside the gap add to them.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one
// capacitance transfer for each item whose index equals the window end.
// Sequencing: the block accepts one item at a time; an unused item passes
// accept and check, a used item also steps the log approximation on the
// single shared multiplier. A window-end item then computes the mean of z
// (reciprocal product, one correction) and the scaled sums, runs the
// bit-serial divider (32 steps) and loads the output register; when the
// scaled xy sum is zero the divider is skipped.
// The finished result sits in the output register; the block takes new
// items while it waits, and stalls only when a second result is ready
// before the first was taken.
// Reset (synchronous, active low) clears the sums, the sequencer, the
// output valid and the registers to their defaults (scale 5447).
// Configuration: APB, registers at 0x0 mode, 0x4 offset, 0x8 scale.
module rc_log_slope_capacitance (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rclsc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rclsc_pkg::t_out_item o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rclsc_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_voltage_mode <= 1'b0;
            r_cfg.zero_offset       <= 16'd0;
            r_cfg.scale_factor      <= 16'd5447;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_HV_MODE: r_cfg.high_voltage_mode <= pwdata[0];
                REG_ZERO:    r_cfg.zero_offset       <= pwdata[15:0];
                REG_SCALE:   r_cfg.scale_factor      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            REG_HV_MODE: prdata = {31'b0, r_cfg.high_voltage_mode};
            REG_ZERO:    prdata = {16'b0, r_cfg.zero_offset};
            REG_SCALE:   prdata = {16'b0, r_cfg.scale_factor};
            default:     prdata = 32'd0;
        endcase
    end

    rclsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rclsc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out_data)
    );
endmodule

// ----- dv/tb_rc_log_slope_capacitance.sv -----
`timescale 1ns / 1ps
module tb_rc_log_slope_capacitance;
    import rclsc_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 2500;
    localparam int unsigned FED_TARGET   = 1950;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_HOLD} t_rx_mode;

    // Predicts capacitance results and keeps them in order of arrival
    class rc_capacitance_scoreboard;
        logic        hv_mode;
        logic [15:0] offset;
        logic [15:0] scale;
        logic [31:0] log_sum;
        logic [31:0] idx_log_sum;
        logic [31:0] win_cnt;
        logic [31:0] win_sx;
        logic [31:0] sxx_shifted;
        t_out_item   capacitance_q[$];
        int          mismatches;
        int          results_checked;

        function new();
            logic [31:0] sxx;
            hv_mode         = 1'b0;
            offset          = 16'd0;
            scale           = 16'd5447;
            log_sum         = '0;
            idx_log_sum     = '0;
            mismatches      = 0;
            results_checked = 0;
            win_cnt         = '0;
            win_sx          = '0;
            sxx             = '0;
            // Fixed x statistics over the used indexes
            for (int k = 0; k < 256; k++) begin
                if (in_window(k)) begin
                    win_cnt = win_cnt + 32'd1;
                    win_sx  = win_sx + 32'(k);
                    sxx     = sxx + 32'(k * k);
                end
            end
            if (win_cnt != 0) sxx = sxx - (win_sx * win_sx) / win_cnt;
            sxx_shifted = sxx >> 3;
        endfunction

        function bit in_window(input int i);
            return (i >= int'(WINDOW_START)) && (i <= int'(WINDOW_END)) &&
                   !((i >= int'(GAP_START)) && (i < int'(GAP_END)));
        endfunction

        // Fixed-point -32768*ln(1 - y/32768)
        function logic [15:0] neg_log(input logic [15:0] y);
            logic [31:0] yw;
            logic [31:0] acc;
            logic [31:0] hi;
            logic [31:0] hi2;
            logic [31:0] t;
            yw  = {16'd0, y};
            acc = yw << 16;
            acc = acc + yw * ((yw + (yw >> 4) + (yw >> 8)) & 32'h0000_FFFF);
            hi  = ((yw * yw) >> 16) & 32'h0000_FFFF;
            hi  = hi >> 2;
            hi2 = hi >> 2;
            acc = acc + yw * (hi - hi2);
            t   = ((hi2 >> 1) * (yw >> 8)) & 32'h0000_FFFF;
            acc = acc + yw * (t - (t >> 3));
            return acc[31:16];
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [31:0] data);
            case (idx)
                REG_HV_MODE: hv_mode = data[0];
                REG_ZERO:    offset  = data[15:0];
                REG_SCALE:   scale   = data[15:0];
                default: ;
            endcase
        endfunction

        // Update the sums for one accepted sample; queue a result at window end
        function void note_sample(input t_in_item it);
            logic [31:0] y;
            logic [31:0] z;
            logic [31:0] mean_z;
            logic [31:0] sxy;
            logic [31:0] q;
            t_out_item   res;
            if (it.sample_index == 8'd0) begin
                log_sum     = '0;
                idx_log_sum = '0;
            end
            if (in_window(int'(it.sample_index))) begin
                y = hv_mode ? (32'd32768 - {17'd0, it.sample}) : {17'd0, it.sample};
                z = {16'd0, neg_log(y[15:0])};
                log_sum     = log_sum + z;
                idx_log_sum = idx_log_sum + {24'd0, it.sample_index} * z;
            end
            if (int'(it.sample_index) != int'(WINDOW_END)) return;
            mean_z = (win_cnt != 0) ? log_sum / win_cnt : 32'd0;
            sxy    = (idx_log_sum - win_sx * mean_z) >> 6;
            if (sxy == 0) begin
                res.capacitance    = 32'hFFFF_FFFF;
                res.divide_by_zero = 1'b1;
            end else begin
                q = (sxx_shifted * {16'd0, scale}) / sxy;
                res.capacitance    = q - {16'd0, offset};
                res.divide_by_zero = 1'b0;
            end
            capacitance_q.push_back(res);
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            results_checked++;
            if (capacitance_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: cap %0d div0 %0b",
                             $realtime, got.capacitance, got.divide_by_zero);
                return;
            end
            want = capacitance_q.pop_front();
            if (got.capacitance !== want.capacitance ||
                got.divide_by_zero !== want.divide_by_zero) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result mismatch: expected cap %0d div0 %0b, got cap %0d div0 %0b",
                             $realtime, want.capacitance, want.divide_by_zero,
                             got.capacitance, got.divide_by_zero);
            end
        endfunction

        function int pending();
            return capacitance_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rc_capacitance_scoreboard sb;
    t_rx_mode rx_mode;
    bit       tx_gappy;
    int       burst_left;
    int       fed_count;

    rc_log_slope_capacitance DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cap the run
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_sample(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Drive output ready according to the current stall pattern
    initial begin
        int       hold_left;
        int       run_left;
        bit       rdy_state;
        t_rx_mode last_mode;
        hold_left = 0;
        run_left  = 0;
        rdy_state = 1'b1;
        last_mode = RX_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (rx_mode == RX_HOLD && last_mode != RX_HOLD) hold_left = HOLD_CYCLES;
            last_mode = rx_mode;
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 99) >= 35);
                RX_BURSTY: begin
                    if (run_left == 0) begin
                        rdy_state = !rdy_state;
                        run_left  = rdy_state ? $urandom_range(1, 20) : $urandom_range(1, 40);
                    end
                    run_left--;
                    i_out_ready <= rdy_state;
                end
                RX_HOLD: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    // Offer one sample and hold it until the transfer; called at a falling edge
    task automatic send_item(input logic [14:0] s, input logic [7:0] ix);
        t_in_item it;
        it.sample       = s;
        it.sample_index = ix;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        fed_count++;
        @(negedge i_clk);
        if (tx_gappy && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic tx_stop();
        i_in_valid <= 1'b0;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic hv, input logic [15:0] off, input logic [15:0] scl);
        reg_write(REG_HV_MODE, {31'd0, hv});
        reg_write(REG_ZERO, {16'd0, off});
        reg_write(REG_SCALE, {16'd0, scl});
    endtask

    // Drain all results, then let the sequencer settle
    task automatic wait_idle();
        tx_stop();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [14:0] pick_sample(input int style, input int ix, input int ramp);
        int v;
        case (style)
            0: v = $urandom_range(0, 32767);
            1: v = ix * ramp + $urandom_range(0, 511);
            default: v = $urandom_range(0, 1) ? 32767 : 0;
        endcase
        if (v > 32767) v = 32767;
        return 15'(v);
    endfunction

    function automatic logic [15:0] pick_reg16(input logic [15:0] dflt);
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return dflt;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Clear, walk the indexes at a fixed stride, end at the window end
    task automatic send_sweep(input int stride, input int style);
        int ix;
        int ramp;
        ramp = $urandom_range(0, 300);
        send_item(pick_sample(style, 0, ramp), 8'd0);
        ix = $urandom_range(1, stride);
        while (ix < int'(WINDOW_END)) begin
            send_item(pick_sample(style, ix, ramp), 8'(ix));
            ix += stride;
        end
        send_item(pick_sample(style, WINDOW_END, ramp), 8'(WINDOW_END));
    endtask

    // Mostly well-formed sweeps, some noise and broken sequences
    task automatic run_random(input int target);
        int r;
        while (fed_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_sweep(($urandom_range(0, 99) < 5) ? 1 : $urandom_range(3, 40),
                           $urandom_range(0, 2));
            end else if (r < 88) begin
                repeat ($urandom_range(1, 6))
                    send_item(15'($urandom_range(0, 32767)), 8'($urandom_range(0, 255)));
            end else if (r < 94) begin
                send_item(15'($urandom_range(0, 32767)), 8'(WINDOW_END));
            end else begin
                send_item(15'($urandom_range(0, 32767)), 8'd0);
                repeat ($urandom_range(1, 8))
                    send_item(15'($urandom_range(0, 32767)),
                              8'($urandom_range(WINDOW_START, WINDOW_END - 1)));
            end
        end
    endtask

    initial begin
        sb         = new();
        rx_mode    = RX_ALWAYS;
        tx_gappy   = 1'b0;
        burst_left = 0;
        fed_count  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b1;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset configuration: empty sums, window and gap edges
        send_item(15'd0, 8'd0);
        send_item(15'd0, 8'(WINDOW_END));          // zero slope -> divide by zero
        send_item(15'h7FFF, 8'(WINDOW_START));
        send_item(15'd0, 8'(WINDOW_START + 1));
        send_item(15'd12345, 8'(GAP_START - 1));
        send_item(15'h7FFF, 8'(GAP_START));        // in the gap, ignored
        send_item(15'd5, 8'(GAP_END - 1));         // in the gap, ignored
        send_item(15'h7FFF, 8'(GAP_END));
        send_item(15'd16384, 8'(WINDOW_END - 1));
        send_item(15'h7FFF, 8'(WINDOW_END));
        send_item(15'd100, 8'd255);
        send_item(15'd7000, 8'(WINDOW_END + 1));
        send_item(15'd1, 8'(WINDOW_START - 1));
        send_item(15'h7FFF, 8'(WINDOW_END));       // sums kept over window end
        send_item(15'h7FFF, 8'd0);
        send_item(15'h7FFF, 8'(WINDOW_END));
        wait_idle();

        // High-voltage mode, extremes of the samples
        write_config(1'b1, 16'd0, 16'hFFFF);
        send_item(15'd0, 8'd0);
        send_item(15'd0, 8'd100);
        send_item(15'h7FFF, 8'd150);
        send_item(15'd0, 8'(WINDOW_END));
        send_item(15'h7FFF, 8'd0);
        send_item(15'h7FFF, 8'(WINDOW_END));
        run_random(fed_count + 300);
        wait_idle();

        // Zero scale, maximum offset, gappy sender, random stalls
        write_config(1'b0, 16'hFFFF, 16'd0);
        rx_mode  = RX_RANDOM;
        tx_gappy = 1'b1;
        run_random(fed_count + 300);
        wait_idle();

        // Long receiver hold-off while short sequences keep coming
        write_config(1'b0, 16'($urandom_range(0, 65535)), 16'd5447);
        rx_mode  = RX_HOLD;
        tx_gappy = 1'b0;
        repeat (30) begin
            send_item(15'($urandom_range(0, 32767)), 8'd0);
            repeat ($urandom_range(0, 3))
                send_item(15'($urandom_range(0, 32767)),
                          8'($urandom_range(WINDOW_START, WINDOW_END - 1)));
            send_item(15'($urandom_range(0, 32767)), 8'(WINDOW_END));
        end
        wait_idle();

        // Random settings until enough samples have gone through
        while (fed_count < FED_TARGET) begin
            write_config(1'($urandom_range(0, 1)), pick_reg16(16'd0), pick_reg16(16'd5447));
            case ($urandom_range(0, 2))
                0: rx_mode = RX_ALWAYS;
                1: rx_mode = RX_RANDOM;
                default: rx_mode = RX_BURSTY;
            endcase
            tx_gappy = 1'($urandom_range(0, 1));
            run_random(fed_count + 250);
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
